// File: rtl/clc_pkg.sv
// Package with the shared constants, codes and controller/datapath types.
package clc_pkg;

  // Sizes of the node pool and of a stored handle.
  localparam int POOL_DEPTH  = 16;
  localparam int VALUE_WIDTH = 16;
  localparam int NODES       = POOL_DEPTH + 1;
  localparam int IDX_W       = $clog2(NODES);
  localparam int POOL_IDX_W  = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CNT_W       = $clog2(POOL_DEPTH + 1);

  // Widths of the channel fields.
  localparam int CMD_W    = 3;
  localparam int HANDLE_W = 16;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_BACK   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FWD    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_INS_A,
    ST_INS_B,
    ST_DEL_A,
    ST_DEL_B,
    ST_DEL_C,
    ST_STEP_A,
    ST_STEP_B,
    ST_VAL,
    ST_RES
  } state_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_DISPATCH,
    OP_INS_LINK,
    OP_INS_HEAD,
    OP_DEL_LINK,
    OP_DEL_FIX,
    OP_STEP_LINK,
    OP_STEP_FIX,
    OP_VALUE,
    OP_RESULT
  } op_t;

  // Command from the controller to the datapath.
  typedef struct packed {
    op_t  op;
    logic rd_zero;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             empty;
    logic             full;
    logic             out_busy;
    logic             cursor_zero;
  } stat_t;

endpackage

// File: rtl/clc_if.sv
// Channel interfaces for the request and result transactions.
interface clc_req_if;
  import clc_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [HANDLE_W-1:0] entry_value;

  modport source (output valid, output command, output entry_value, input ready);
  modport sink   (input valid, input command, input entry_value, output ready);
endinterface

interface clc_res_if;
  import clc_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                cursor_valid;
  logic [HANDLE_W-1:0] cursor_value;
  logic [COUNT_W-1:0]  entry_count;

  modport source (output valid, output status, output cursor_valid, output cursor_value,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input cursor_valid, input cursor_value,
                  input entry_count, output ready);
endinterface

// File: rtl/circular_list_with_cursor_core.sv
// Top level of the circular list with cursor: controller, datapath and checks.
//
// A command transaction enters on the request channel (command, entry_value) and
// exactly one result transaction leaves on the result channel (status,
// cursor_valid, cursor_value, entry_count) for every command, in order.
// Commands are handled one at a time. The request channel is ready only while
// the controller is idle; a command then walks the next and previous link
// memories, each with one write port and one registered read port. A read or a
// rejected command passes through dispatch, value read and result load; insert,
// delete and step add their own link states after dispatch. A new command is
// accepted once the controller returns to idle after its result is loaded.
// The result sits in an output register; when the receiver stalls it holds
// there and the next command is still accepted and processed, waiting only
// at its own result load until the register is taken.
// A synchronous reset empties the list: the cursor returns to the sentinel,
// the count clears, all nodes become free and all links read as zero.
module circular_list_with_cursor_core (
  input  logic      clk,
  input  logic      rst,
  clc_req_if.sink   request,
  clc_res_if.source result
);
  import clc_pkg::*;

  ctrl_t ctrl;
  stat_t st;

  clc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_ready (request.ready),
    .st        (st),
    .ctrl      (ctrl)
  );

  clc_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .st           (st),
    .command      (request.command),
    .entry_value  (request.entry_value),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .status       (result.status),
    .cursor_valid (result.cursor_valid),
    .cursor_value (result.cursor_value),
    .entry_count  (result.entry_count)
  );

  // Between commands the cursor rests on the sentinel exactly when the list is empty.
  a_cursor_empty: assert property (@(posedge clk) disable iff (rst)
    request.ready |-> (st.empty == st.cursor_zero))
    else $error("cursor and count disagree on an empty list");

  // A command is dispatched only in the cycle after its request was taken.
  a_dispatch_after_accept: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == OP_DISPATCH) |-> $past(request.valid && request.ready))
    else $error("dispatch without an accepted request");

  // A result is never loaded over one the receiver has not taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == OP_RESULT) |-> !(result.valid && !result.ready))
    else $error("result register overwritten while stalled");

  // No request is taken while a command is still in progress.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == OP_DISPATCH) |=> !request.ready)
    else $error("request accepted during a command");

endmodule

// File: rtl/clc_datapath.sv
// Datapath: link memories, node values, free map, cursor, count and result register.
module clc_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  clc_pkg::ctrl_t                ctrl,
  output clc_pkg::stat_t                st,
  input  logic [clc_pkg::CMD_W-1:0]     command,
  input  logic [clc_pkg::HANDLE_W-1:0]  entry_value,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [clc_pkg::STATUS_W-1:0]  status,
  output logic                          cursor_valid,
  output logic [clc_pkg::HANDLE_W-1:0]  cursor_value,
  output logic [clc_pkg::COUNT_W-1:0]   entry_count
);
  import clc_pkg::*;

  // Link and value memories.
  logic [IDX_W-1:0]       next_mem [NODES];
  logic [IDX_W-1:0]       prev_mem [NODES];
  logic [VALUE_WIDTH-1:0] value_mem [NODES];
  logic [NODES-1:0]       next_set;
  logic [NODES-1:0]       prev_set;

  // Control and working registers.
  logic [POOL_DEPTH-1:0]  in_use;
  logic [IDX_W-1:0]       cursor;
  logic [CNT_W-1:0]       count;
  logic [CMD_W-1:0]       cmd_r;
  logic [VALUE_WIDTH-1:0] val_r;
  logic [STATUS_W-1:0]    status_r;
  logic [IDX_W-1:0]       free_idx;
  logic [IDX_W-1:0]       tmp;
  logic [IDX_W-1:0]       next_raw;
  logic [IDX_W-1:0]       prev_raw;
  logic                   next_ok;
  logic                   prev_ok;
  logic [VALUE_WIDTH-1:0] val_rd;

  // Combinational signals.
  logic [IDX_W-1:0]       rd_addr;
  logic [IDX_W-1:0]       rd_next;
  logic [IDX_W-1:0]       rd_prev;
  logic                   next_we;
  logic [IDX_W-1:0]       next_wa;
  logic [IDX_W-1:0]       next_wd;
  logic                   prev_we;
  logic [IDX_W-1:0]       prev_wa;
  logic [IDX_W-1:0]       prev_wd;
  logic [POOL_DEPTH-1:0]  free_vec;
  logic [POOL_DEPTH-1:0]  free_onehot;
  logic [IDX_W-1:0]       free_enc;
  logic [IDX_W-1:0]       cur_off;
  logic [IDX_W-1:0]       free_off;
  logic                   is_back;
  logic [IDX_W-1:0]       step_link;
  logic [IDX_W-1:0]       fix_link;
  logic [STATUS_W-1:0]    status_next;
  logic                   list_empty;
  logic                   list_full;

  assign list_empty = (count == '0);
  assign list_full  = (count == CNT_W'(POOL_DEPTH));
  assign is_back    = (cmd_r == CMD_BACK);

  // Status toward the controller.
  assign st.cmd         = cmd_r;
  assign st.empty       = list_empty;
  assign st.full        = list_full;
  assign st.out_busy    = res_valid && !res_ready;
  assign st.cursor_zero = (cursor == '0);

  // Unwritten links read as zero, which is the reset value of every link.
  assign rd_next = next_ok ? next_raw : '0;
  assign rd_prev = prev_ok ? prev_raw : '0;
  assign rd_addr = ctrl.rd_zero ? '0 : cursor;

  // Lowest free pool node: isolate the lowest set bit, then encode it.
  assign free_vec    = ~in_use;
  assign free_onehot = free_vec & (~free_vec + 1'b1);
  always_comb begin
    free_enc = '0;
    for (int k = 0; k < POOL_DEPTH; k++) begin
      if (free_onehot[k]) begin
        free_enc = free_enc | IDX_W'(k + 1);
      end
    end
  end

  assign cur_off  = cursor - 1'b1;
  assign free_off = free_idx - 1'b1;

  // Link chosen by a step and the fallback around the sentinel.
  assign step_link = is_back ? rd_prev : rd_next;
  assign fix_link  = (tmp != '0) ? tmp : step_link;

  // Status of a command, decided when it is dispatched.
  always_comb begin
    if (cmd_r == CMD_INSERT) begin
      status_next = list_full ? STATUS_FULL : STATUS_DONE;
    end else if ((cmd_r == CMD_DELETE) || (cmd_r == CMD_BACK) ||
                 (cmd_r == CMD_FWD) || (cmd_r == CMD_READ)) begin
      status_next = list_empty ? STATUS_EMPTY : STATUS_DONE;
    end else begin
      status_next = STATUS_DONE;
    end
  end

  // Link write ports.
  always_comb begin
    next_we = 1'b0;
    next_wa = '0;
    next_wd = '0;
    prev_we = 1'b0;
    prev_wa = '0;
    prev_wd = '0;
    case (ctrl.op)
      OP_INS_LINK: begin
        next_we = 1'b1;
        next_wa = free_idx;
        next_wd = rd_next;
        prev_we = 1'b1;
        prev_wa = free_idx;
        prev_wd = '0;
      end
      OP_INS_HEAD: begin
        next_we = 1'b1;
        next_wa = '0;
        next_wd = free_idx;
        prev_we = 1'b1;
        prev_wa = tmp;
        prev_wd = free_idx;
      end
      OP_DEL_LINK: begin
        next_we = 1'b1;
        next_wa = rd_prev;
        next_wd = rd_next;
        prev_we = 1'b1;
        prev_wa = rd_next;
        prev_wd = rd_prev;
      end
      default: begin
      end
    endcase
  end

  // Link memories with registered reads.
  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    next_raw <= next_mem[rd_addr];
    prev_raw <= prev_mem[rd_addr];
  end

  // Value memory, written on insert and read at the cursor.
  always_ff @(posedge clk) begin
    if (ctrl.op == OP_INS_LINK) begin
      value_mem[free_idx] <= val_r;
    end
    if (ctrl.op == OP_VALUE) begin
      val_rd <= value_mem[cursor];
    end
  end

  // Link valid flags, free map, cursor, count and result handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      next_set  <= '0;
      prev_set  <= '0;
      next_ok   <= 1'b0;
      prev_ok   <= 1'b0;
      in_use    <= '0;
      cursor    <= '0;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (next_we) begin
        next_set[next_wa] <= 1'b1;
      end
      if (prev_we) begin
        prev_set[prev_wa] <= 1'b1;
      end
      next_ok <= next_set[rd_addr];
      prev_ok <= prev_set[rd_addr];
      case (ctrl.op)
        OP_INS_LINK: begin
          in_use[free_off[POOL_IDX_W-1:0]] <= 1'b1;
          count <= count + 1'b1;
          if (list_empty) begin
            cursor <= free_idx;
          end
        end
        OP_DEL_LINK: begin
          in_use[cur_off[POOL_IDX_W-1:0]] <= 1'b0;
          count <= count - 1'b1;
        end
        OP_DEL_FIX: begin
          cursor <= (tmp != '0) ? tmp : rd_next;
        end
        OP_STEP_FIX: begin
          cursor <= fix_link;
        end
        default: begin
        end
      endcase
      if (ctrl.op == OP_RESULT) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_CAPTURE: begin
        cmd_r <= command;
        val_r <= VALUE_WIDTH'(entry_value);
      end
      OP_DISPATCH: begin
        status_r <= status_next;
        free_idx <= free_enc;
      end
      OP_INS_LINK: begin
        tmp <= rd_next;
      end
      OP_DEL_LINK: begin
        tmp <= rd_next;
      end
      OP_STEP_LINK: begin
        tmp <= step_link;
      end
      OP_RESULT: begin
        status       <= status_r;
        cursor_valid <= (cursor != '0);
        cursor_value <= (cursor != '0) ? HANDLE_W'(val_rd) : '0;
        entry_count  <= COUNT_W'(count);
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/clc_ctrl.sv
// Controller: sequences each command through the datapath steps.
module clc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  clc_pkg::stat_t  st,
  output clc_pkg::ctrl_t  ctrl
);
  import clc_pkg::*;

  state_t state;
  state_t state_next;
  logic   cmd_list;

  // Commands that need a non-empty list.
  assign cmd_list = (st.cmd == CMD_DELETE) || (st.cmd == CMD_BACK) ||
                    (st.cmd == CMD_FWD) || (st.cmd == CMD_READ);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if ((st.cmd == CMD_INSERT) && !st.full) begin
          state_next = ST_INS_A;
        end else if (cmd_list && !st.empty && (st.cmd == CMD_DELETE)) begin
          state_next = ST_DEL_A;
        end else if (cmd_list && !st.empty &&
                     ((st.cmd == CMD_BACK) || (st.cmd == CMD_FWD))) begin
          state_next = ST_STEP_A;
        end else begin
          state_next = ST_VAL;
        end
      end
      ST_INS_A:  state_next = ST_INS_B;
      ST_INS_B:  state_next = ST_VAL;
      ST_DEL_A:  state_next = ST_DEL_B;
      ST_DEL_B:  state_next = ST_DEL_C;
      ST_DEL_C:  state_next = ST_VAL;
      ST_STEP_A: state_next = ST_STEP_B;
      ST_STEP_B: state_next = ST_VAL;
      ST_VAL:    state_next = ST_RES;
      ST_RES: begin
        if (!st.out_busy) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // Outputs toward the datapath and the request channel.
  always_comb begin
    ctrl.op      = OP_NONE;
    ctrl.rd_zero = 1'b0;
    req_ready    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          ctrl.op = OP_CAPTURE;
        end
      end
      ST_DISPATCH: begin
        ctrl.op      = OP_DISPATCH;
        ctrl.rd_zero = (st.cmd == CMD_INSERT);
      end
      ST_INS_A:  ctrl.op = OP_INS_LINK;
      ST_INS_B:  ctrl.op = OP_INS_HEAD;
      ST_DEL_A:  ctrl.op = OP_DEL_LINK;
      ST_DEL_B:  ctrl.rd_zero = 1'b1;
      ST_DEL_C:  ctrl.op = OP_DEL_FIX;
      ST_STEP_A: begin
        ctrl.op      = OP_STEP_LINK;
        ctrl.rd_zero = 1'b1;
      end
      ST_STEP_B: ctrl.op = OP_STEP_FIX;
      ST_VAL:    ctrl.op = OP_VALUE;
      ST_RES: begin
        if (!st.out_busy) begin
          ctrl.op = OP_RESULT;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
